>>> rtl/assert_macros.svh
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/stoc_pkg.sv
// Shared types and constants of the sorted table occurrence counter.
`default_nettype none

package stoc_pkg;

    localparam int VALUE_W = 32;
    localparam int IDX_W   = 8;
    localparam int LEN_W   = 9;
    localparam int COUNT_W = 9;

    // Item command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic wr;       // store the accepted entry
        logic load;     // start a query: latch target, open both search windows
        logic probe;    // register midpoints and read the table
        logic update;   // compare read data and narrow the windows
        logic capture;  // load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic busy;     // at least one search window is still open
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/stoc_lane.sv
// One binary search lane: window bounds, midpoint and last match position.
`default_nettype none

module stoc_lane #(
    parameter int AW = 8,
    parameter int LW = 10
) (
    input  wire                          i_clk,
    input  wire                          i_find_last,
    input  stoc_pkg::t_dp_cmd            i_cmd,
    input  wire logic signed [LW-1:0]    i_hi_init,
    input  wire logic signed [stoc_pkg::VALUE_W-1:0] i_target,
    input  wire logic signed [stoc_pkg::VALUE_W-1:0] i_rdata,
    output logic                         o_active,
    output logic [AW-1:0]                o_addr,
    output logic signed [LW-1:0]         o_found
);
    import stoc_pkg::*;

    localparam logic signed [LW-1:0] ONE = LW'(1);

    logic signed [LW-1:0] r_lo;
    logic signed [LW-1:0] r_hi;
    logic signed [LW-1:0] r_mid;
    logic signed [LW-1:0] r_found;
    logic signed [LW-1:0] w_diff;
    logic signed [LW-1:0] w_mid;

    // Window open while lo <= hi; midpoint without overflow
    assign o_active = (r_lo <= r_hi);
    assign w_diff   = r_hi - r_lo;
    assign w_mid    = r_lo + (w_diff >>> 1);
    assign o_addr   = AW'(w_mid);
    assign o_found  = r_found;

    // Window update
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo    <= '0;
            r_hi    <= i_hi_init;
            r_found <= '1;
        end
        if (i_cmd.probe) begin
            r_mid <= w_mid;
        end
        if (i_cmd.update && o_active) begin
            if (i_rdata == i_target) begin
                r_found <= r_mid;
                if (i_find_last) begin
                    r_lo <= r_mid + ONE;
                end else begin
                    r_hi <= r_mid - ONE;
                end
            end else if (i_rdata > i_target) begin
                r_hi <= r_mid - ONE;
            end else begin
                r_lo <= r_mid + ONE;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/stoc_datapath.sv
// Datapath: table memory, length register, two search lanes, result register.
`default_nettype none

module stoc_datapath #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  stoc_pkg::t_dp_cmd                    i_cmd,
    input  wire                                  i_cfg_valid,
    input  wire [stoc_pkg::LEN_W-1:0]            i_cfg_data,
    input  wire [stoc_pkg::IDX_W-1:0]            i_entry_index,
    input  wire logic signed [stoc_pkg::VALUE_W-1:0] i_value,
    output stoc_pkg::t_dp_status                 o_status,
    output logic [stoc_pkg::COUNT_W-1:0]         o_match_count
);
    import stoc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = AW + 2;
    localparam logic signed [LW-1:0] ONE = LW'(1);

    logic signed [VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] r_rd_l;
    logic signed [VALUE_W-1:0] r_rd_r;
    logic signed [VALUE_W-1:0] r_target;
    logic [LEN_W-1:0]          r_used_length;
    logic [COUNT_W-1:0]        r_match_count;

    logic [31:0]               w_len;
    logic signed [LW-1:0]      w_hi_init;
    logic                      w_wr_en;
    logic                      w_act_l;
    logic                      w_act_r;
    logic [AW-1:0]             w_addr_l;
    logic [AW-1:0]             w_addr_r;
    logic signed [LW-1:0]      w_found_l;
    logic signed [LW-1:0]      w_found_r;
    logic signed [LW-1:0]      w_span;
    logic [COUNT_W-1:0]        w_count;

    // Length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_length <= '0;
        end else if (i_cfg_valid) begin
            r_used_length <= i_cfg_data;
        end
    end

    // Search length saturates at the table depth
    assign w_len     = (32'(r_used_length) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                              : 32'(r_used_length);
    assign w_hi_init = $signed(LW'(w_len)) - ONE;

    // Target latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= i_value;
        end
    end

    // Table: one write port, two registered read ports
    assign w_wr_en = i_cmd.wr && (32'(i_entry_index) < 32'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[AW'(i_entry_index)] <= i_value;
        end
        if (i_cmd.probe) begin
            r_rd_l <= r_mem[w_addr_l];
            r_rd_r <= r_mem[w_addr_r];
        end
    end

    // Leftmost and rightmost lanes
    stoc_lane #(
        .AW (AW),
        .LW (LW)
    ) u_lane_left (
        .i_clk       (i_clk),
        .i_find_last (1'b0),
        .i_cmd       (i_cmd),
        .i_hi_init   (w_hi_init),
        .i_target    (r_target),
        .i_rdata     (r_rd_l),
        .o_active    (w_act_l),
        .o_addr      (w_addr_l),
        .o_found     (w_found_l)
    );

    stoc_lane #(
        .AW (AW),
        .LW (LW)
    ) u_lane_right (
        .i_clk       (i_clk),
        .i_find_last (1'b1),
        .i_cmd       (i_cmd),
        .i_hi_init   (w_hi_init),
        .i_target    (r_target),
        .i_rdata     (r_rd_r),
        .o_active    (w_act_r),
        .o_addr      (w_addr_r),
        .o_found     (w_found_r)
    );

    assign o_status.busy = w_act_l || w_act_r;

    // Count: zero when absent or when the matches are out of order
    assign w_span  = w_found_r - w_found_l + ONE;
    assign w_count = (!w_found_l[LW-1] && (w_found_r >= w_found_l)) ? COUNT_W'(w_span)
                                                                    : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_match_count <= w_count;
        end
    end

    assign o_match_count = r_match_count;

endmodule

`default_nettype wire

>>> rtl/stoc_ctrl.sv
// Controller: item handshake, search sequencing and result valid.
`default_nettype none

module stoc_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire                   i_cmd,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire                   i_stall,
    input  stoc_pkg::t_dp_status  i_status,
    output stoc_pkg::t_dp_cmd     o_cmd
);
    import stoc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // State and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_cmd == CMD_QUERY) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_PROBE;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (i_status.busy) begin
                    o_cmd.probe = 1'b1;
                    n_state     = ST_CMP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_CMP: begin
                o_cmd.update = 1'b1;
                n_state      = ST_PROBE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on capture, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

>>> rtl/sorted_table_occurrence_count.sv
// Sorted table occurrence counter: writes fill the table, queries count matches of a target.
// Write item: stored without stall, no result; the next item is taken in the following cycle.
// Query item: both searches run side by side, each probe round a read then a compare.
// Rounds R: at most ceil(log2(len+1)) of the saturated length, 9 at 256, 0 when empty.
// Capture after the last round, then idle for the next item; later while a result waits.
// Synchronous active-low reset clears length, controller and result valid; table undefined.
`default_nettype none

module sorted_table_occurrence_count #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire                                   i_cmd,
    input  wire [stoc_pkg::IDX_W-1:0]             i_entry_index,
    input  wire logic signed [stoc_pkg::VALUE_W-1:0] i_value,
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic [stoc_pkg::COUNT_W-1:0]          o_match_count,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [stoc_pkg::LEN_W-1:0]             i_cfg_data
);
    import stoc_pkg::*;

    `include "assert_macros.svh"

    t_dp_cmd    s_cmd;
    t_dp_status s_status;
    logic       s_take_query;
    logic       s_take_write;
    logic       s_searching;
    logic       s_starting;

    assign o_cfg_ready = 1'b1;

    // Controller
    stoc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd    (i_cmd),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (s_status),
        .o_cmd    (s_cmd)
    );

    // Datapath
    stoc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_entry_index),
        .i_value       (i_value),
        .o_status      (s_status),
        .o_match_count (o_match_count)
    );

    // Terms for the checks
    assign s_take_query = i_valid && !o_stall && (i_cmd == CMD_QUERY);
    assign s_take_write = i_valid && !o_stall && (i_cmd == CMD_WRITE);
    assign s_searching  = s_cmd.probe || s_cmd.update;
    assign s_starting   = s_cmd.wr || s_cmd.load;

    // Checks
    `ASSERT_NEXT(a_capture_shows_result, s_cmd.capture, o_valid, "capture without result valid")
    `ASSERT_NEXT(a_query_blocks_input, s_take_query, o_stall, "query did not block input")
    `ASSERT_NEXT(a_write_keeps_ready, s_take_write, !o_stall, "write blocked input")
    `ASSERT_IMPLY(a_no_write_in_search, s_searching, !s_starting, "write or load during search")

endmodule

`default_nettype wire

>>> verif/stoc_count_checker.sv
// Checker for the sorted table occurrence counter: mirrors table and length, predicts each count.
`timescale 1ns / 1ps

module stoc_count_checker #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    input  wire                                 i_in_stall,
    input  wire                                 i_cmd,
    input  wire [stoc_pkg::IDX_W-1:0]           i_entry_index,
    input  wire signed [stoc_pkg::VALUE_W-1:0]  i_value,
    input  wire                                 i_out_valid,
    input  wire                                 i_out_stall,
    input  wire [stoc_pkg::COUNT_W-1:0]         i_match_count,
    input  wire                                 i_cfg_valid,
    input  wire                                 i_cfg_ready,
    input  wire [stoc_pkg::LEN_W-1:0]           i_cfg_data,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_checked,
    output int                                  o_nonzero
);
    import stoc_pkg::*;

    typedef struct packed {
        logic signed [VALUE_W-1:0] target;
        logic [COUNT_W-1:0]        count;
    } t_expected;

    logic signed [VALUE_W-1:0] entries [TABLE_DEPTH];
    logic [LEN_W-1:0]          search_len = '0;
    t_expected                 expected_counts [$];
    int                        errors  = 0;
    int                        checked = 0;
    int                        nonzero = 0;

    // Binary search over the searched prefix; leftmost or rightmost match, -1 if none
    function automatic int find_match(input logic signed [VALUE_W-1:0] target,
                                      input bit rightmost);
        int n, lo, hi, mid, pos;
        n   = (search_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(search_len);
        lo  = 0;
        hi  = n - 1;
        pos = -1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (entries[mid] == target) begin
                pos = mid;
                if (rightmost) lo = mid + 1;
                else hi = mid - 1;
            end else if (entries[mid] > target) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return pos;
    endfunction

    // Count of entries equal to target; zero when absent or when the searches cross
    function automatic logic [COUNT_W-1:0] count_matches(
        input logic signed [VALUE_W-1:0] target);
        int first, final_pos;
        first     = find_match(target, 1'b0);
        final_pos = find_match(target, 1'b1);
        if (first >= 0 && final_pos >= first) return COUNT_W'(final_pos - first + 1);
        return '0;
    endfunction

    // Watch all three channels; results are matched before new items are queued
    always @(posedge i_clk) begin : watch
        t_expected exp_item;
        if (!i_rst_n) begin
            expected_counts.delete();
            search_len = '0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_counts.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("stoc_checker: result %0d with no query outstanding",
                                 i_match_count);
                end else begin
                    exp_item = expected_counts.pop_front();
                    checked++;
                    if (i_match_count !== exp_item.count) begin
                        errors++;
                        if (errors <= 10)
                            $display("stoc_checker: target %0d: expected count %0d, got %0d",
                                     exp_item.target, exp_item.count, i_match_count);
                    end else if (exp_item.count != 0) begin
                        nonzero++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                search_len = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                if (i_cmd == CMD_WRITE) begin
                    entries[i_entry_index] = i_value;
                end else begin
                    exp_item.target = i_value;
                    exp_item.count  = count_matches(i_value);
                    expected_counts.push_back(exp_item);
                end
            end
        end
        o_errors  <= errors;
        o_pending <= expected_counts.size();
        o_checked <= checked;
        o_nonzero <= nonzero;
    end

endmodule

>>> verif/tb_top.sv
// Testbench top for the sorted table occurrence counter: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
    import stoc_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int RESULT_GAP  = 24;    // a bit over the longest query latency
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_TARGET = 750;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

    logic                      i_clk;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      i_cmd         = CMD_WRITE;
    logic [IDX_W-1:0]          i_entry_index = '0;
    logic signed [VALUE_W-1:0] i_value       = '0;
    logic                      i_stall       = 1'b0;
    logic                      i_cfg_valid   = 1'b0;
    logic [LEN_W-1:0]          i_cfg_data    = '0;
    wire                       o_stall;
    wire                       o_valid;
    wire                       o_cfg_ready;
    wire [COUNT_W-1:0]         o_match_count;

    int errors, pending, checked, nonzero;

    int                        hold_reqs  = 0;
    int                        holds_done = 0;
    bit                        calm       = 1'b0;
    logic signed [VALUE_W-1:0] shadow [TABLE_DEPTH];
    int                        items_sent = 0;
    int                        active_len = 0;

    sorted_table_occurrence_count #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_entry_index(i_entry_index),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_match_count(o_match_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    stoc_count_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_cmd        (i_cmd),
        .i_entry_index(i_entry_index),
        .i_value      (i_value),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_match_count(o_match_count),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_nonzero    (nonzero)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Result side: random stalls, or one long hold-off on request
    initial begin : result_sink
        int hold_left;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_done) begin
                i_stall   <= 1'b1;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0) begin
                    @(posedge i_clk);
                    hold_left--;
                end
                holds_done++;
            end else begin
                i_stall <= !calm && ($urandom_range(0, 99) < 35);
            end
        end
    end

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic signed [VALUE_W-1:0] val);
        while (!calm && $urandom_range(0, 99) < 35) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_entry_index <= idx;
        i_value       <= val;
        do @(posedge i_clk); while (o_stall);
        if (cmd == CMD_WRITE) shadow[idx] = val;
        items_sent++;
    endtask

    // Stop offering items until every count is back and the block has settled
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (RESULT_GAP) @(posedge i_clk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] len);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        active_len  = (len > TABLE_DEPTH) ? TABLE_DEPTH : int'(len);
    endtask

    initial begin : stimulus
        int                        phase, len_pick, mode, mix_items, idx, r, rand_start;
        longint                    cur, step_max;
        logic signed [VALUE_W-1:0] tgt;
        logic [LEN_W-1:0]          cfg_val;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table straight out of reset
        send_item(CMD_QUERY, IDX_W'($urandom), 32'sd0);

        // Small sorted table with both extremes and a run of three
        send_item(CMD_WRITE, 8'd0, VALUE_MIN);
        send_item(CMD_WRITE, 8'd1, -32'sd5);
        send_item(CMD_WRITE, 8'd2, 32'sd3);
        send_item(CMD_WRITE, 8'd3, 32'sd3);
        send_item(CMD_WRITE, 8'd4, 32'sd3);
        send_item(CMD_WRITE, 8'd5, 32'sd100);
        send_item(CMD_WRITE, 8'd6, VALUE_MAX);
        send_item(CMD_WRITE, 8'd7, VALUE_MAX);
        send_item(CMD_WRITE, 8'd255, 32'sh5555_aaaa);
        wait_idle();
        set_length(9'd8);
        send_item(CMD_QUERY, IDX_W'($urandom), VALUE_MIN);
        send_item(CMD_QUERY, IDX_W'($urandom), 32'sd3);
        send_item(CMD_QUERY, IDX_W'($urandom), VALUE_MAX);
        send_item(CMD_QUERY, IDX_W'($urandom), 32'sd4);
        send_item(CMD_QUERY, IDX_W'($urandom), 32'sd0);
        send_item(CMD_QUERY, IDX_W'($urandom), -32'sd5);
        send_item(CMD_QUERY, IDX_W'($urandom), 32'sd100);

        // One entry out of order: searches can miss or cross
        send_item(CMD_WRITE, 8'd2, 32'sd200);
        send_item(CMD_QUERY, IDX_W'($urandom), 32'sd3);
        send_item(CMD_QUERY, IDX_W'($urandom), 32'sd200);
        wait_idle();
        set_length(9'd0);
        send_item(CMD_QUERY, IDX_W'($urandom), 32'sd3);

        // Random phases: sorted fill, new length, then mixed queries and writes
        phase      = 0;
        rand_start = items_sent;
        while (items_sent - rand_start < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (phase == 2) len_pick = TABLE_DEPTH;
            else if (r < 6) len_pick = 0;
            else if (r < 25) len_pick = $urandom_range(17, 80);
            else len_pick = $urandom_range(1, 16);

            // phase 3 keeps the full table and searches it with an oversized length
            if (phase != 3) begin
                mode = $urandom_range(0, 2);
                case (mode)
                    0: begin
                        cur      = longint'($urandom_range(0, 2000)) - 1000;
                        step_max = 1;
                    end
                    1: begin
                        cur      = longint'($signed($urandom));
                        step_max = 64'sd1 << 20;
                    end
                    default: begin
                        cur      = -64'sd2147483648;
                        step_max = (64'sd1 << 33) / ((len_pick > 0) ? len_pick : 1);
                    end
                endcase
                for (idx = 0; idx < len_pick; idx++) begin
                    if (idx > 0) cur += longint'({$urandom, $urandom} % (step_max + 1));
                    if (cur > 64'sd2147483647) cur = 64'sd2147483647;
                    send_item(CMD_WRITE, IDX_W'(idx), cur[31:0]);
                end
            end

            // every entry is written from phase 2 on, so any length is safe then
            if (phase == 2) cfg_val = 9'd256;
            else if (phase == 3) cfg_val = 9'h1ff;
            else if (phase > 3 && $urandom_range(0, 99) < 15) cfg_val = LEN_W'($urandom);
            else cfg_val = LEN_W'(len_pick);
            wait_idle();
            set_length(cfg_val);

            if (phase == 4) hold_reqs++;
            calm      <= (phase == 6);
            mix_items = (phase == 4) ? 40 : $urandom_range(8, 30);
            repeat (mix_items) begin
                r = $urandom_range(0, 99);
                if (r < 62) begin
                    r = $urandom_range(0, 99);
                    if (active_len > 0 && r < 60)
                        tgt = shadow[$urandom_range(0, active_len - 1)];
                    else if (active_len > 0 && r < 75)
                        tgt = shadow[$urandom_range(0, active_len - 1)] +
                              ((r % 2) ? 32'sd1 : -32'sd1);
                    else if (r < 90) tgt = $urandom;
                    else if (r < 94) tgt = VALUE_MIN;
                    else if (r < 97) tgt = VALUE_MAX;
                    else tgt = 32'sd0;
                    send_item(CMD_QUERY, IDX_W'($urandom), tgt);
                end else if (r < 80 && active_len > 0) begin
                    // copy a neighbor: order holds, run lengths shift
                    idx = $urandom_range(0, active_len - 1);
                    if (idx > 0 && $urandom_range(0, 1)) tgt = shadow[idx - 1];
                    else if (idx < active_len - 1) tgt = shadow[idx + 1];
                    else tgt = shadow[idx];
                    send_item(CMD_WRITE, IDX_W'(idx), tgt);
                end else if (r < 93 && active_len < TABLE_DEPTH) begin
                    send_item(CMD_WRITE,
                              IDX_W'($urandom_range(active_len, TABLE_DEPTH - 1)), $urandom);
                end else begin
                    // noise anywhere, may leave the table unsorted
                    send_item(CMD_WRITE, IDX_W'($urandom), $urandom);
                end
            end
            phase++;
        end

        wait_idle();
        $display("tb_top: %0d items sent over %0d phases, %0d counts compared, %0d non-zero",
                 items_sent, phase, checked, nonzero);
        $display("tb_top: lengths 0..511 incl. full and oversized table, %0d-cycle output hold",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/stoc_pkg.sv
rtl/stoc_lane.sv
rtl/stoc_datapath.sv
rtl/stoc_ctrl.sv
rtl/sorted_table_occurrence_count.sv
verif/stoc_count_checker.sv
verif/tb_top.sv
